### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the postfix evaluator.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define PBE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check a property at every clock edge, reset included.
`define PBE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/pbe_pkg.sv
// Package of the postfix boolean evaluator: token modes, status codes, sizes.
// No dependencies; used by the channel interfaces and the core.
package pbe_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int VAR_COUNT   = 26;
    localparam int MODE_W      = 3;
    localparam int VIDX_W      = 5;
    localparam int STATUS_W    = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_VAR   = 3'd0,
        MODE_NOT   = 3'd1,
        MODE_AND   = 3'd2,
        MODE_OR    = 3'd3,
        MODE_IMPL  = 3'd4,
        MODE_EQUIV = 3'd5
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_UNDERFLOW = 2'd1,
        STATUS_OVERFLOW  = 2'd2
    } status_t;

endpackage

### rtl/pbe_token_if.sv
// Token channel of the postfix evaluator: valid/ready plus one token.
// Depends on pbe_pkg for field widths.
interface pbe_token_if;
    logic                          valid;
    logic                          ready;
    logic [pbe_pkg::MODE_W-1:0]    mode;
    logic [pbe_pkg::VIDX_W-1:0]    var_index;
    logic                          last;

    modport source (output valid, output mode, output var_index, output last, input ready);
    modport sink   (input valid, input mode, input var_index, input last, output ready);
endinterface

### rtl/pbe_result_if.sv
// Result channel of the postfix evaluator: valid/ready plus value and status.
// Depends on pbe_pkg for field widths.
interface pbe_result_if;
    logic                          valid;
    logic                          ready;
    logic                          value;
    logic [pbe_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

### rtl/postfix_boolean_evaluator_core.sv
// Result: registered, and shown in the cycle after the transfer of a token marked last.
// Throughput: one token per cycle; a token is taken while the result register
// is empty or being drained in the same cycle, set by the single result register.
// Reset: clears stack count, error code, variable values and result valid;
// stack contents are undefined until pushed. Depends on pbe_pkg and both interfaces.
`include "assert_macros.svh"

module postfix_boolean_evaluator_core #(
    parameter int STACK_DEPTH = pbe_pkg::STACK_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pbe_pkg::VAR_COUNT-1:0]  cfg_wdata,
    pbe_token_if.sink                      token,
    pbe_result_if.source                   result
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    logic [pbe_pkg::VAR_COUNT-1:0] var_values_reg;
    logic [STACK_DEPTH-1:0]        stack_reg;
    logic [STACK_DEPTH-1:0]        stack_next;
    logic [STACK_DEPTH-1:0]        stack_pop;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_op;
    logic [CNT_W-1:0]              count_next;
    logic [pbe_pkg::STATUS_W-1:0]  err_reg;
    logic [pbe_pkg::STATUS_W-1:0]  err_op;
    logic [pbe_pkg::STATUS_W-1:0]  err_next;
    logic                          res_valid_reg;
    logic                          res_value_reg;
    logic [pbe_pkg::STATUS_W-1:0]  res_status_reg;
    logic                          res_value_next;
    logic [pbe_pkg::STATUS_W-1:0]  res_status_next;
    logic                          tok_xfer;
    logic                          var_bit;
    logic                          a_bit;
    logic                          b_bit;
    logic                          op_bit;
    logic                          has_one;
    logic                          has_two;
    logic                          is_full;

    assign token.ready   = !res_valid_reg || result.ready;
    assign tok_xfer      = token.valid && token.ready;
    assign result.valid  = res_valid_reg;
    assign result.value  = res_value_reg;
    assign result.status = res_status_reg;

    assign var_bit   = (token.var_index < pbe_pkg::VIDX_W'(pbe_pkg::VAR_COUNT))
                       ? var_values_reg[token.var_index] : 1'b0;
    assign b_bit     = stack_reg[0];
    assign a_bit     = stack_reg[1];
    assign has_one   = (count_reg != '0);
    assign has_two   = (count_reg >= CNT_W'(2));
    assign is_full   = (count_reg >= CNT_W'(STACK_DEPTH));
    assign stack_pop = stack_reg >> 1;

    always_comb
    begin
        case (token.mode)
            pbe_pkg::MODE_AND:  op_bit = a_bit & b_bit;
            pbe_pkg::MODE_OR:   op_bit = a_bit | b_bit;
            pbe_pkg::MODE_IMPL: op_bit = ~a_bit | b_bit;
            default:            op_bit = ~(a_bit ^ b_bit);
        endcase
    end

    always_comb
    begin
        stack_next = stack_reg;
        count_op   = count_reg;
        err_op     = err_reg;
        case (token.mode) inside
            pbe_pkg::MODE_VAR:
            begin
                if (is_full)
                begin
                    if (err_reg == pbe_pkg::STATUS_OK)
                    begin
                        err_op = pbe_pkg::STATUS_OVERFLOW;
                    end
                end
                else
                begin
                    stack_next = {stack_reg[STACK_DEPTH-2:0], var_bit};
                    count_op   = count_reg + CNT_W'(1);
                end
            end
            pbe_pkg::MODE_NOT:
            begin
                if (!has_one)
                begin
                    if (err_reg == pbe_pkg::STATUS_OK)
                    begin
                        err_op = pbe_pkg::STATUS_UNDERFLOW;
                    end
                end
                else
                begin
                    stack_next = {stack_reg[STACK_DEPTH-1:1], ~stack_reg[0]};
                end
            end
            pbe_pkg::MODE_AND, pbe_pkg::MODE_OR, pbe_pkg::MODE_IMPL, pbe_pkg::MODE_EQUIV:
            begin
                if (!has_two)
                begin
                    if (err_reg == pbe_pkg::STATUS_OK)
                    begin
                        err_op = pbe_pkg::STATUS_UNDERFLOW;
                    end
                end
                else
                begin
                    stack_next = {stack_pop[STACK_DEPTH-1:1], op_bit};
                    count_op   = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                stack_next = stack_reg;
            end
        endcase

        if (count_op == '0)
        begin
            res_value_next  = 1'b0;
            res_status_next = (err_op != pbe_pkg::STATUS_OK) ? err_op
                              : pbe_pkg::STATUS_UNDERFLOW;
        end
        else
        begin
            res_value_next  = stack_next[0];
            res_status_next = err_op;
        end

        count_next = token.last ? '0 : count_op;
        err_next   = token.last ? pbe_pkg::STATUS_OK : err_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            var_values_reg <= '0;
            count_reg      <= '0;
            err_reg        <= pbe_pkg::STATUS_OK;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                var_values_reg <= cfg_wdata;
            end
            if (tok_xfer)
            begin
                count_reg <= count_next;
                err_reg   <= err_next;
            end
            if (tok_xfer && token.last)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Hold stack and result payload; no reset needed.
    always_ff @(posedge clk)
    begin
        if (tok_xfer)
        begin
            stack_reg <= stack_next;
        end
        if (tok_xfer && token.last)
        begin
            res_value_reg  <= res_value_next;
            res_status_reg <= res_status_next;
        end
    end

    `PBE_ASSERT_ALWAYS(a_count_bound, clk,
        count_reg <= CNT_W'(STACK_DEPTH),
        "stack count above depth")
    `PBE_ASSERT(a_last_clears, clk, rst_n,
        (tok_xfer && token.last) |=> (count_reg == '0 && err_reg == pbe_pkg::STATUS_OK),
        "stack not cleared after last token")
    `PBE_ASSERT(a_result_source, clk, rst_n,
        $rose(res_valid_reg) |-> $past(tok_xfer && token.last),
        "result raised without a last token")
    `PBE_ASSERT(a_error_sticky, clk, rst_n,
        (err_reg != pbe_pkg::STATUS_OK && !(tok_xfer && token.last))
            |=> (err_reg == $past(err_reg)),
        "recorded error changed before clear")

endmodule
